// ===== rtl/sbtl_pkg.sv =====
// types and constants shared by the sorted bounded target list
// no dependencies; used by the channel interfaces, the search unit and the top level
`default_nettype none

package sbtl_pkg;

   localparam int ID_W   = 10;
   localparam int KEY_W  = 32;
   localparam int RPOS_W = 6;
   localparam int OUT_W  = 7;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_CLEAR  = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [KEY_W-1:0] key;
   } entry_type;

   typedef struct packed {
      logic start;
      logic step;
   } search_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/sbtl_req_if.sv =====
// request channel: valid/ready handshake carrying one action word
// depends on sbtl_pkg
`default_nettype none

interface sbtl_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic [sbtl_pkg::ID_W-1:0]    entity_id;
   logic [sbtl_pkg::KEY_W-1:0]   distance_key;
   logic [sbtl_pkg::RPOS_W-1:0]  read_position;

   modport source (output valid, action, entity_id, distance_key, read_position,
                   input ready);
   modport sink   (input valid, action, entity_id, distance_key, read_position,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/sbtl_rsp_if.sv =====
// response channel: valid/ready handshake carrying one result word
// depends on sbtl_pkg
`default_nettype none

interface sbtl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        accepted;
   logic                        dropped_last;
   logic [sbtl_pkg::OUT_W-1:0]  insert_position;
   logic [sbtl_pkg::OUT_W-1:0]  entry_count;
   logic                        read_valid;
   logic [sbtl_pkg::ID_W-1:0]   read_entity_id;
   logic [sbtl_pkg::KEY_W-1:0]  read_distance_key;

   modport source (output valid, accepted, dropped_last, insert_position, entry_count,
                   read_valid, read_entity_id, read_distance_key,
                   input ready);
   modport sink   (input valid, accepted, dropped_last, insert_position, entry_count,
                   read_valid, read_entity_id, read_distance_key,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/sbtl_search_unit.sv =====
// binary search bounds with one shared adder and one key compare per step
// depends on sbtl_pkg; driven by the sequencer in sorted_bounded_target_list
`default_nettype none

module sbtl_search_unit #(
   parameter int CAPACITY = 64
) (
   input  wire                               clock,
   input  wire sbtl_pkg::search_ctrl_type    ctrl,
   input  wire [$clog2(CAPACITY+1)-1:0]      count,
   input  wire [sbtl_pkg::KEY_W-1:0]         key,
   input  wire [sbtl_pkg::KEY_W-1:0]         probe_key,
   output logic [$clog2(CAPACITY)-1:0]       mid,
   output logic [$clog2(CAPACITY+1)-1:0]     pos,
   output logic                              done
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);

   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW:0]   sum;
   logic [CW-1:0] mid_w;

   assign sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_w = sum[CW:1];
   assign mid   = mid_w[IW-1:0];
   assign pos   = lo_ff;
   assign done  = !(lo_ff < hi_ff);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (ctrl.start) begin
         lo_in = '0;
         hi_in = count;
      end else if (ctrl.step) begin
         if (probe_key <= key) begin
            lo_in = mid_w + CW'(1);
         end else begin
            hi_in = mid_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

endmodule

`default_nettype wire

// ===== rtl/sorted_bounded_target_list.sv =====
// sorted bounded target list: up to CAPACITY entries kept in ascending key order
// depends on sbtl_pkg, sbtl_req_if, sbtl_rsp_if and sbtl_search_unit
//
// req_ch takes one word per item: insert, clear or read of one list position.
// rsp_ch gives exactly one result word per item, in order.
// the list lives in a single-port-write, single-port-read memory with registered
// read data; the work runs as a series of accesses to it under a small sequencer,
// and req_ch.ready is high only while the sequencer waits for a new word.
// insert: binary search, each halving a read of the middle entry then a key compare,
// then a final check of the bounds; a key whose position would be CAPACITY is rejected
// and goes straight to the result; else each entry above the position is moved one
// place up by a read and a write, then the new entry is written and the result
// register is loaded. clear, read and an unused action code go straight to the result.
// the result register holds a finished word while rsp_ch stalls; the sequencer
// then waits with the next result until that word is taken.
// reset empties the list at once (count to zero); entries are never cleared,
// since only positions below the count are ever read.
`default_nettype none

module sorted_bounded_target_list #(
   parameter int CAPACITY = 64
) (
   input  wire        clock,
   input  wire        reset,
   sbtl_req_if.sink   req_ch,
   sbtl_rsp_if.source rsp_ch
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);
   localparam int XW = (CW > sbtl_pkg::RPOS_W) ? CW : sbtl_pkg::RPOS_W;
   localparam int OW = sbtl_pkg::OUT_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SRCH  = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_SHRD  = 3'd3;
   localparam logic [2:0] S_SHWR  = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]                      state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [sbtl_pkg::ID_W-1:0]       id_ff, id_in;
   logic [sbtl_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [CW-1:0]                   pos_ff, pos_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic                            acc_ff, acc_in;
   logic                            drop_ff, drop_in;
   logic                            rvalid_ff, rvalid_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_acc_ff, rsp_acc_in;
   logic                            rsp_drop_ff, rsp_drop_in;
   logic [sbtl_pkg::OUT_W-1:0]      rsp_ipos_ff, rsp_ipos_in;
   logic [sbtl_pkg::OUT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic                            rsp_rvalid_ff, rsp_rvalid_in;
   logic [sbtl_pkg::ID_W-1:0]       rsp_rid_ff, rsp_rid_in;
   logic [sbtl_pkg::KEY_W-1:0]      rsp_rkey_ff, rsp_rkey_in;

   sbtl_pkg::entry_type             entry_mem_ff [CAPACITY];
   sbtl_pkg::entry_type             rd_data_ff;
   logic                            rd_en;
   logic [IW-1:0]                   rd_addr;
   logic                            wr_en;
   logic [IW-1:0]                   wr_addr;
   sbtl_pkg::entry_type             wr_data;

   sbtl_pkg::search_ctrl_type       srch_ctrl;
   logic [IW-1:0]                   srch_mid;
   logic [CW-1:0]                   srch_pos;
   logic                            srch_done;

   logic                            req_take;
   logic                            rsp_free;
   logic [XW-1:0]                   rpos_x;
   logic [XW-1:0]                   count_x;

   sbtl_search_unit #(
      .CAPACITY (CAPACITY)
   ) u_search (
      .clock     (clock),
      .ctrl      (srch_ctrl),
      .count     (count_ff),
      .key       (key_ff),
      .probe_key (rd_data_ff.key),
      .mid       (srch_mid),
      .pos       (srch_pos),
      .done      (srch_done)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rpos_x       = XW'(req_ch.read_position);
   assign count_x      = XW'(count_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      id_in         = id_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      drop_in       = drop_ff;
      rvalid_in     = rvalid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_ipos_in   = rsp_ipos_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_rid_in    = rsp_rid_ff;
      rsp_rkey_in   = rsp_rkey_ff;
      rd_en         = 1'b0;
      rd_addr       = srch_mid;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data_ff;
      srch_ctrl     = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               id_in     = req_ch.entity_id;
               key_in    = req_ch.distance_key;
               pos_in    = '0;
               acc_in    = 1'b0;
               drop_in   = 1'b0;
               rvalid_in = 1'b0;
               state_in  = S_DONE;
               case (req_ch.action)
                  sbtl_pkg::ACT_INSERT: begin
                     srch_ctrl.start = 1'b1;
                     state_in        = S_SRCH;
                  end
                  sbtl_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  sbtl_pkg::ACT_READ: begin
                     if (rpos_x < count_x) begin
                        rvalid_in = 1'b1;
                        rd_en     = 1'b1;
                        rd_addr   = IW'(req_ch.read_position);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SRCH: begin
            if (srch_done) begin
               pos_in = srch_pos;
               if (srch_pos == CW'(CAPACITY)) begin
                  state_in = S_DONE;
               end else begin
                  acc_in = 1'b1;
                  if (count_ff == CW'(CAPACITY)) begin
                     drop_in  = 1'b1;
                     count_in = count_ff - CW'(1);
                     idx_in   = IW'(count_ff - CW'(1));
                  end else begin
                     idx_in   = IW'(count_ff);
                  end
                  state_in = S_SHRD;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = srch_mid;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            srch_ctrl.step = 1'b1;
            state_in       = S_SRCH;
         end
         S_SHRD: begin
            if (CW'(idx_ff) > pos_ff) begin
               rd_en    = 1'b1;
               rd_addr  = idx_ff - IW'(1);
               state_in = S_SHWR;
            end else begin
               state_in = S_WRITE;
            end
         end
         S_SHWR: begin
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_data  = rd_data_ff;
            idx_in   = idx_ff - IW'(1);
            state_in = S_SHRD;
         end
         S_WRITE: begin
            wr_en       = 1'b1;
            wr_addr     = IW'(pos_ff);
            wr_data.id  = id_ff;
            wr_data.key = key_ff;
            count_in    = count_ff + CW'(1);
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = acc_ff;
               rsp_drop_in   = drop_ff;
               rsp_ipos_in   = OW'(pos_ff);
               rsp_count_in  = OW'(count_ff);
               rsp_rvalid_in = rvalid_ff;
               rsp_rid_in    = rvalid_ff ? rd_data_ff.id : '0;
               rsp_rkey_in   = rvalid_ff ? rd_data_ff.key : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff         <= id_in;
      key_ff        <= key_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      drop_ff       <= drop_in;
      rvalid_ff     <= rvalid_in;
      rsp_acc_ff    <= rsp_acc_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_ipos_ff   <= rsp_ipos_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_rid_ff    <= rsp_rid_in;
      rsp_rkey_ff   <= rsp_rkey_in;
   end

   // list storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.accepted          = rsp_acc_ff;
   assign rsp_ch.dropped_last      = rsp_drop_ff;
   assign rsp_ch.insert_position   = rsp_ipos_ff;
   assign rsp_ch.entry_count       = rsp_count_ff;
   assign rsp_ch.read_valid        = rsp_rvalid_ff;
   assign rsp_ch.read_entity_id    = rsp_rid_ff;
   assign rsp_ch.read_distance_key = rsp_rkey_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_shift_above_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHWR) |-> (CW'(idx_ff) > pos_ff))
      else $error("shift writes at or below the insert position");

   a_drop_needs_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) && drop_ff |=> (count_ff == CW'(CAPACITY)))
      else $error("eviction did not leave a full list");

   a_ready_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_free |=> rsp_ch.valid && req_ch.ready)
      else $error("finished item did not reach the result register");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking bench for sorted_bounded_target_list: inserts, clears, reads and unused action codes with an
// in-bench list predictor; depends on sbtl_pkg, sbtl_req_if, sbtl_rsp_if and the top level
`timescale 1ns / 100ps

module testbench;

   localparam int         CAPACITY    = 64;
   localparam int         IXW         = $clog2(CAPACITY);
   localparam int         ID_W        = sbtl_pkg::ID_W;
   localparam int         KEY_W       = sbtl_pkg::KEY_W;
   localparam int         RPOS_W      = sbtl_pkg::RPOS_W;
   localparam int         OUT_W       = sbtl_pkg::OUT_W;
   localparam int         NUM_OPS     = 650;
   localparam int         QUIET_LIMIT = 4000;
   localparam int         HOLD_CYCLES = 300;
   localparam logic [1:0] ACT_SPARE   = 2'd3;

   typedef struct {
      logic [1:0]        action;
      logic [ID_W-1:0]   entity_id;
      logic [KEY_W-1:0]  distance_key;
      logic [RPOS_W-1:0] read_position;
      bit                drain_first;
   } list_op_t;

   typedef struct {
      logic              accepted;
      logic              dropped_last;
      logic [OUT_W-1:0]  insert_position;
      logic [OUT_W-1:0]  entry_count;
      logic              read_valid;
      logic [ID_W-1:0]   read_entity_id;
      logic [KEY_W-1:0]  read_distance_key;
   } list_answer_t;

   logic clock;
   logic reset;

   sbtl_req_if req_ch ();
   sbtl_rsp_if rsp_ch ();

   sorted_bounded_target_list #(.CAPACITY(CAPACITY)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   list_op_t     op_queue[$];
   list_answer_t answer_queue[$];

   logic [ID_W-1:0]  list_ids[CAPACITY];
   logic [KEY_W-1:0] list_keys[CAPACITY];
   int unsigned      list_count;

   int fail_count;
   int n_pushed;
   int n_sent;
   int n_results;
   int quiet_cycles;
   int holdoff_left;
   bit holdoff_done;

   // upper-bound binary search, shift up, evict or reject on a full list; also clear and read
   function automatic list_answer_t update_list(list_op_t op);
      list_answer_t ans;
      int unsigned  lo;
      int unsigned  hi;
      int unsigned  mid;
      int unsigned  i;
      ans = '{default: '0};
      case (op.action)
         sbtl_pkg::ACT_INSERT: begin
            lo = 0;
            hi = list_count;
            while (lo < hi) begin
               mid = (lo + hi) / 2;
               if (list_keys[mid[IXW-1:0]] <= op.distance_key) lo = mid + 1;
               else hi = mid;
            end
            ans.insert_position = lo[OUT_W-1:0];
            if (lo < CAPACITY) begin
               ans.accepted = 1'b1;
               if (list_count == CAPACITY) begin
                  ans.dropped_last = 1'b1;
                  list_count--;
               end
               for (i = list_count; i > lo; i--) begin
                  list_ids[i[IXW-1:0]]  = list_ids[IXW'(i-1)];
                  list_keys[i[IXW-1:0]] = list_keys[IXW'(i-1)];
               end
               list_ids[lo[IXW-1:0]]  = op.entity_id;
               list_keys[lo[IXW-1:0]] = op.distance_key;
               list_count++;
            end
         end
         sbtl_pkg::ACT_CLEAR: list_count = 0;
         sbtl_pkg::ACT_READ: begin
            if (32'(op.read_position) < list_count) begin
               ans.read_valid        = 1'b1;
               ans.read_entity_id    = list_ids[op.read_position];
               ans.read_distance_key = list_keys[op.read_position];
            end
         end
         default: ;
      endcase
      ans.entry_count = list_count[OUT_W-1:0];
      return ans;
   endfunction

   task automatic add_op(input logic [1:0] action, input logic [ID_W-1:0] id,
                         input logic [KEY_W-1:0] key, input logic [RPOS_W-1:0] rpos,
                         input bit drain);
      list_op_t op;
      op.action        = action;
      op.entity_id     = id;
      op.distance_key  = key;
      op.read_position = rpos;
      op.drain_first   = drain;
      op_queue.push_back(op);
      n_pushed++;
   endtask

   function automatic logic [KEY_W-1:0] pick_key(int mode);
      int sel;
      sel = $urandom_range(0, 3);
      case (mode)
         0: return $urandom;
         1: return $urandom_range(0, 31);
         default: begin
            if (sel == 0) return '0;
            else if (sel == 1) return '1;
            else return $urandom;
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [KEY_W-1:0] expected,
                              input logic [KEY_W-1:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0d actual %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.action        = sbtl_pkg::ACT_CLEAR;
      req_ch.entity_id     = '0;
      req_ch.distance_key  = '0;
      req_ch.read_position = '0;
      rsp_ch.ready         = 1'b0;
   end

   // stimulus
   initial begin
      int key_mode;
      int n_ins;
      int k;
      fail_count = 0;
      n_pushed   = 0;
      list_count = 0;

      add_op(sbtl_pkg::ACT_CLEAR,  '0,       '0,            '0,    0);
      add_op(sbtl_pkg::ACT_READ,   '1,       '1,            '0,    0);
      add_op(ACT_SPARE,            '1,       '1,            '1,    0);
      add_op(sbtl_pkg::ACT_INSERT, '0,       '0,            '1,    0);
      add_op(sbtl_pkg::ACT_INSERT, '1,       '1,            '0,    0);
      add_op(sbtl_pkg::ACT_INSERT, 10'd5,    '0,            '0,    0);
      add_op(sbtl_pkg::ACT_INSERT, 10'h2aa,  32'h8000_0000, '0,    0);
      add_op(sbtl_pkg::ACT_INSERT, 10'h155,  32'h7fff_ffff, '0,    0);
      for (k = 0; k < 5; k++) add_op(sbtl_pkg::ACT_READ, '0, '0, k[RPOS_W-1:0], 0);
      add_op(sbtl_pkg::ACT_READ,   '0,       '0,            6'd5,  0);
      add_op(sbtl_pkg::ACT_READ,   '0,       '0,            '1,    0);
      add_op(ACT_SPARE,            '0,       '0,            '0,    0);
      add_op(sbtl_pkg::ACT_CLEAR,  '1,       '1,            '1,    0);
      add_op(sbtl_pkg::ACT_READ,   '0,       '0,            '0,    0);
      add_op(sbtl_pkg::ACT_INSERT, 10'd7,    32'd100,       '0,    0);
      add_op(sbtl_pkg::ACT_READ,   '0,       '0,            '0,    0);

      // rounds that mostly fill the list, so eviction and rejection come up often
      while (n_pushed < NUM_OPS) begin
         key_mode = $urandom_range(0, 2);
         if ($urandom_range(0, 1)) n_ins = $urandom_range(64, 96);
         else n_ins = $urandom_range(4, 40);
         for (k = 0; k < n_ins && n_pushed < NUM_OPS; k++) begin
            add_op(sbtl_pkg::ACT_INSERT, ID_W'($urandom_range(0, 1023)), pick_key(key_mode),
                   RPOS_W'($urandom_range(0, 63)), k == 0);
            if ($urandom_range(0, 3) == 0)
               add_op(sbtl_pkg::ACT_READ, ID_W'($urandom_range(0, 1023)), $urandom,
                      RPOS_W'($urandom_range(0, 63)), 0);
            if ($urandom_range(0, 49) == 0)
               add_op(ACT_SPARE, ID_W'($urandom_range(0, 1023)), $urandom,
                      RPOS_W'($urandom_range(0, 63)), 0);
         end
         repeat (4)
            add_op(sbtl_pkg::ACT_READ, ID_W'($urandom_range(0, 1023)), $urandom,
                   RPOS_W'($urandom_range(0, 63)), 0);
         if ($urandom_range(0, 2) != 0)
            add_op(sbtl_pkg::ACT_CLEAR, ID_W'($urandom_range(0, 1023)), $urandom,
                   RPOS_W'($urandom_range(0, 63)), 1);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (op_queue.size() != 0 || answer_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         n_sent = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            answer_queue.push_back(update_list(op_queue[0]));
            void'(op_queue.pop_front());
            n_sent++;
         end
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (op_queue.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (op_queue[0].drain_first && answer_queue.size() != 0) begin
               req_ch.valid <= 1'b0;
            end else if (!(n_sent >= 300 && n_sent < 420) && $urandom_range(0, 99) < 33) begin
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid         <= 1'b1;
               req_ch.action        <= op_queue[0].action;
               req_ch.entity_id     <= op_queue[0].entity_id;
               req_ch.distance_key  <= op_queue[0].distance_key;
               req_ch.read_position <= op_queue[0].read_position;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      list_answer_t exp_ans;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         n_results    = 0;
         holdoff_left = 0;
         holdoff_done = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (answer_queue.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               exp_ans = answer_queue.pop_front();
               check_field("accepted", KEY_W'(exp_ans.accepted), KEY_W'(rsp_ch.accepted));
               check_field("dropped_last", KEY_W'(exp_ans.dropped_last),
                           KEY_W'(rsp_ch.dropped_last));
               check_field("insert_position", KEY_W'(exp_ans.insert_position),
                           KEY_W'(rsp_ch.insert_position));
               check_field("entry_count", KEY_W'(exp_ans.entry_count),
                           KEY_W'(rsp_ch.entry_count));
               check_field("read_valid", KEY_W'(exp_ans.read_valid),
                           KEY_W'(rsp_ch.read_valid));
               check_field("read_entity_id", KEY_W'(exp_ans.read_entity_id),
                           KEY_W'(rsp_ch.read_entity_id));
               check_field("read_distance_key", exp_ans.read_distance_key,
                           rsp_ch.read_distance_key);
            end
         end
         if (!holdoff_done && n_results == 150) begin
            holdoff_done = 1;
            holdoff_left = HOLD_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!(n_results >= 300 && n_results < 420) && $urandom_range(0, 99) < 33) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule

// ===== files.f =====
rtl/sbtl_pkg.sv
rtl/sbtl_req_if.sv
rtl/sbtl_rsp_if.sv
rtl/sbtl_search_unit.sv
rtl/sorted_bounded_target_list.sv
tb/sv/testbench.sv
